[rtl/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue_unit.
package spq_pkg;

  localparam int unsigned CapacityDef = 128;
  localparam int unsigned DataW       = 32;
  localparam int unsigned OccW        = 8;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  localparam logic signed [DataW-1:0] UnderflowValue = '1;

  typedef struct packed {
    cmd_t                    cmd;
    logic signed [DataW-1:0] item_value;
    logic signed [DataW-1:0] item_priority;
  } in_item_t;

  typedef struct packed {
    status_t                 status;
    logic signed [DataW-1:0] removed_value;
    logic [OccW-1:0]         occupancy;
  } out_result_t;

  // One stored pair.
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] rank;
  } entry_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic   do_insert;
    logic   do_remove;
    entry_t item;
  } cell_op_t;

endpackage

[rtl/spq_cell.sv]
// One slot of the sorted chain: holds a pair, compares it to the new item
// and shifts with its neighbors. Depends on spq_pkg.
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_op_t op,
  input  logic              occupied,
  input  logic              prev_ge,
  input  spq_pkg::entry_t   prev_entry,
  input  spq_pkg::entry_t   next_entry,
  output spq_pkg::entry_t   entry,
  output logic              ge
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // New item goes behind this slot when it holds an equal or higher priority.
  assign ge    = occupied && (entry_r.rank >= op.item.rank);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (op.do_insert) begin
      if (ge) begin
        entry_nxt = entry_r;
      end else if (prev_ge) begin
        entry_nxt = op.item;
      end else begin
        entry_nxt = prev_entry;
      end
    end else if (op.do_remove) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

[rtl/sorted_priority_queue_unit.sv]
// Top level of the sorted priority queue: count, result register and the
// chain of spq_cell slots. Depends on spq_pkg and spq_cell.
//
//   channel  | ports                   | beat taken when
//   ---------+-------------------------+---------------------------
//   input    | start, busy, in_item    | start high and busy low
//   result   | out_strobe, out_result  | every cycle out_strobe is high
//
// One command a cycle: all slots compare against the new priority in
// parallel and shift by at most one place.
// The result is registered and appears in the cycle after its command, for one cycle.
// Synchronous active-low reset empties the queue; slot contents are not cleared.
// busy stays low; the receiver cannot stall, so nothing ever backs up.
module sorted_priority_queue_unit #(
  parameter int unsigned CAPACITY = spq_pkg::CapacityDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  spq_pkg::in_item_t    in_item,
  output logic                 out_strobe,
  output spq_pkg::out_result_t out_result
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] count_r;
  logic [CntW-1:0] count_nxt;
  logic            strobe_r;
  out_result_t     result_r;
  out_result_t     result_nxt;

  cell_op_t          op;
  logic              accept;
  logic              full;
  logic              empty;
  entry_t            cell_entry [CAPACITY];
  logic [CAPACITY:0] cell_ge;
  logic [CntW+OccW-1:0] occ_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CntW'(CAPACITY));
  assign empty  = (count_r == '0);

  assign op.do_insert = accept && (in_item.cmd == CMD_INSERT) && !full;
  assign op.do_remove = accept && (in_item.cmd == CMD_REMOVE) && !empty;
  assign op.item.value = in_item.item_value;
  assign op.item.rank  = in_item.item_priority;

  // Front slot has nothing ahead of it.
  assign cell_ge[0] = 1'b1;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   occ;

    assign occ = (count_r > CntW'(i));

    if (i == 0) begin : g_first
      assign prev_e = op.item;
    end else begin : g_mid
      assign prev_e = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_e = cell_entry[i];
    end else begin : g_body
      assign next_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .op         (op),
      .occupied   (occ),
      .prev_ge    (cell_ge[i]),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .entry      (cell_entry[i]),
      .ge         (cell_ge[i+1])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (op.do_insert) begin
      count_nxt = count_r + 1'b1;
    end else if (op.do_remove) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign occ_ext = {{OccW{1'b0}}, count_nxt};

  always_comb begin
    result_nxt.removed_value = '0;
    result_nxt.status        = ST_OK;
    result_nxt.occupancy     = occ_ext[OccW-1:0];
    if (in_item.cmd == CMD_INSERT) begin
      if (full) begin
        result_nxt.status = ST_OVERFLOW;
      end
    end else if (empty) begin
      result_nxt.status        = ST_UNDERFLOW;
      result_nxt.removed_value = UnderflowValue;
    end else begin
      result_nxt.removed_value = cell_entry[0].value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= accept;
    end
  end

  // Hold payload only on an accepted beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_strobe = strobe_r;
  assign out_result = result_r;

endmodule
